### hw/rtl/rtp_fu_nal_reassembler_assert.svh
// Assertion macros for the checker file of the RTP FU reassembler.
// No dependencies; include by bare file name.
`ifndef RTP_FU_NAL_REASSEMBLER_ASSERT_SVH
`define RTP_FU_NAL_REASSEMBLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RTPFU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rtpfu assertion failed");

// Next-cycle implication, disabled during reset.
`define RTPFU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rtpfu assertion failed");

`endif

### hw/rtl/rtpfu_pkg.sv
// Package for the RTP FU reassembler: types, codes and constants.
// No dependencies; used by every module of the block.
`default_nettype none
package rtpfu_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [3:0] HDR_LEN_RESET = 4'd12;
    localparam logic [4:0] POS_MAX       = 5'd31;
    localparam logic [4:0] AVC_FU_TYPE   = 5'd28;
    localparam logic [5:0] HEVC_FU_TYPE  = 6'd49;
    localparam logic [7:0] SC_ZERO       = 8'h00;
    localparam logic [7:0] SC_ONE        = 8'h01;

    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_AVC    = 2'd1,
        KIND_HEVC   = 2'd2
    } kind_t;

    // Output sequencer steps: start code bytes, data byte, trailing 01.
    typedef logic [2:0] step_t;
    localparam step_t STEP_SC_FIRST = 3'd0;
    localparam step_t STEP_SC_LAST  = 3'd3;
    localparam step_t STEP_DATA     = 3'd4;
    localparam step_t STEP_EXTRA    = 3'd5;

    // One command from the classifier to the output sequencer.
    typedef struct packed {
        logic       start;  // prefix 00 00 00 01
        logic       extra;  // trailing 01 after data (H.265 header)
        logic [7:0] data;
        logic       e;      // NAL end on the final beat
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage
`default_nettype wire

### hw/rtl/rtpfu_front.sv
// Front end: header skip, payload classification, command generation.
// Depends on rtpfu_pkg.
`default_nettype none
module rtpfu_front
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [3:0]       cfg_hdr_len,
    input  wire logic             accept,
    input  wire logic [7:0]       in_byte,
    input  wire logic             packet_last,
    output logic                  cmd_push,
    output rtpfu_pkg::cmd_t       cmd
);

    logic [3:0]         hdr_len_reg;
    logic [4:0]         pos_reg, pos_next;
    rtpfu_pkg::kind_t   kind_reg, kind_next;
    logic [7:0]         ind_reg, ind_next;
    logic               endf_reg, endf_next;

    logic [4:0]         hdr_len_ext;
    logic [4:0]         rel;
    logic [4:0]         fu_pos;
    logic               past_hdr;
    logic               cmd_valid;
    logic [7:0]         fu_hdr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_len_reg <= rtpfu_pkg::HDR_LEN_RESET;
            pos_reg     <= '0;
            kind_reg    <= rtpfu_pkg::KIND_SINGLE;
            ind_reg     <= '0;
            endf_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                hdr_len_reg <= cfg_hdr_len;
            end
            pos_reg  <= pos_next;
            kind_reg <= kind_next;
            ind_reg  <= ind_next;
            endf_reg <= endf_next;
        end
    end

    always_comb
    begin
        hdr_len_ext = {1'b0, hdr_len_reg};
        past_hdr    = (pos_reg >= hdr_len_ext);
        rel         = pos_reg - hdr_len_ext;
        fu_pos      = (kind_reg == rtpfu_pkg::KIND_AVC) ? 5'd1 : 5'd2;

        // rebuilt NAL header from indicator and FU header
        if (kind_reg == rtpfu_pkg::KIND_AVC)
        begin
            fu_hdr = {ind_reg[7:5], in_byte[4:0]};
        end
        else
        begin
            fu_hdr = {ind_reg[7], in_byte[5:0], ind_reg[0]};
        end

        cmd_valid = 1'b0;
        cmd       = '0;
        kind_next = kind_reg;
        ind_next  = ind_reg;
        endf_next = endf_reg;
        pos_next  = pos_reg;

        if (accept)
        begin
            if (past_hdr)
            begin
                if (rel == 5'd0)
                begin
                    ind_next = in_byte;
                    if (in_byte[4:0] == rtpfu_pkg::AVC_FU_TYPE)
                    begin
                        kind_next = rtpfu_pkg::KIND_AVC;
                    end
                    else if (in_byte[6:1] == rtpfu_pkg::HEVC_FU_TYPE)
                    begin
                        kind_next = rtpfu_pkg::KIND_HEVC;
                    end
                    else
                    begin
                        kind_next = rtpfu_pkg::KIND_SINGLE;
                        cmd_valid = 1'b1;
                        cmd.start = 1'b1;
                        cmd.data  = in_byte;
                        cmd.e     = packet_last;
                    end
                end
                else if (kind_reg == rtpfu_pkg::KIND_SINGLE)
                begin
                    cmd_valid = 1'b1;
                    cmd.data  = in_byte;
                    cmd.e     = packet_last;
                end
                else if (rel == fu_pos)
                begin
                    endf_next = in_byte[6];
                    if (in_byte[7])
                    begin
                        cmd_valid = 1'b1;
                        cmd.start = 1'b1;
                        cmd.extra = (kind_reg == rtpfu_pkg::KIND_HEVC);
                        cmd.data  = fu_hdr;
                        cmd.e     = packet_last & in_byte[6];
                    end
                end
                else if (rel > fu_pos)
                begin
                    cmd_valid = 1'b1;
                    cmd.data  = in_byte;
                    cmd.e     = packet_last & endf_reg;
                end
                // H.265 second header byte falls through: dropped
            end

            if (packet_last)
            begin
                pos_next  = '0;
                kind_next = rtpfu_pkg::KIND_SINGLE;
                ind_next  = '0;
                endf_next = 1'b0;
            end
            else if (pos_reg < rtpfu_pkg::POS_MAX)
            begin
                pos_next = pos_reg + 5'd1;
            end
        end

        cmd_push = cmd_valid;
    end

endmodule
`default_nettype wire

### hw/rtl/rtpfu_cmd_fifo.sv
// Short command queue between classifier and output sequencer.
// Depends on rtpfu_pkg.
`default_nettype none
module rtpfu_cmd_fifo
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire rtpfu_pkg::cmd_t    wdata,
    input  wire logic               pop,
    output rtpfu_pkg::cmd_t         rdata,
    output rtpfu_pkg::fifo_status_t status
);

    localparam int AW = rtpfu_pkg::FIFO_AW;
    localparam logic [AW:0] DEPTH = (AW + 1)'(rtpfu_pkg::FIFO_DEPTH);

    rtpfu_pkg::cmd_t mem_reg [rtpfu_pkg::FIFO_DEPTH];
    logic [AW-1:0]   wptr_reg;
    logic [AW-1:0]   rptr_reg;
    logic [AW:0]     count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + AW'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (AW + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (AW + 1)'(1);
            end
        end
    end

    assign rdata        = mem_reg[rptr_reg];
    assign status.full  = (count_reg == DEPTH);
    assign status.empty = (count_reg == '0);

endmodule
`default_nettype wire

### hw/rtl/rtpfu_back.sv
// Back end: expands queued commands into output beats, with output register.
// Depends on rtpfu_pkg.
`default_nettype none
module rtpfu_back
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rtpfu_pkg::cmd_t    q_data,
    input  wire logic               q_empty,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              out_byte,
    output logic                    nal_end,
    output logic                    run_last
);

    rtpfu_pkg::cmd_t  cur_reg;
    logic             cur_valid_reg, cur_valid_next;
    rtpfu_pkg::step_t step_reg, step_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             nal_end_reg, nal_end_next;
    logic             run_last_reg, run_last_next;

    logic             slot_free;
    logic             emit;
    logic             cur_last;
    logic [7:0]       beat;

    always_comb
    begin
        slot_free = !out_valid_reg || out_ready;
        emit      = slot_free && cur_valid_reg;
        cur_last  = (step_reg == rtpfu_pkg::STEP_EXTRA) ||
                    ((step_reg == rtpfu_pkg::STEP_DATA) && !cur_reg.extra);

        if (step_reg < rtpfu_pkg::STEP_SC_LAST)
        begin
            beat = rtpfu_pkg::SC_ZERO;
        end
        else if (step_reg == rtpfu_pkg::STEP_DATA)
        begin
            beat = cur_reg.data;
        end
        else
        begin
            beat = rtpfu_pkg::SC_ONE;
        end

        q_pop = !q_empty && (!cur_valid_reg || (emit && cur_last));

        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (emit)
        begin
            if (cur_last)
            begin
                cur_valid_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + rtpfu_pkg::step_t'(1);
            end
        end
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            step_next      = q_data.start ? rtpfu_pkg::STEP_SC_FIRST : rtpfu_pkg::STEP_DATA;
        end

        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        nal_end_next   = nal_end_reg;
        run_last_next  = run_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = beat;
            nal_end_next   = cur_last && cur_reg.e;
            run_last_next  = cur_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= rtpfu_pkg::STEP_SC_FIRST;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        out_byte_reg <= out_byte_next;
        nal_end_reg  <= nal_end_next;
        run_last_reg <= run_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign nal_end   = nal_end_reg;
    assign run_last  = run_last_reg;

endmodule
`default_nettype wire

### hw/rtl/rtp_fu_nal_reassembler.sv
// Top level of the RTP FU reassembler: classifier, command queue, sequencer.
// Depends on rtpfu_pkg, rtpfu_front, rtpfu_cmd_fifo, rtpfu_back.
//
// Usage
//   Input channel: one RTP packet byte per beat (in_byte), packet_last set on
//   the final byte of each packet. Output channel: Annex-B byte stream, one
//   byte per beat; nal_end flags the last byte of a NAL unit, run_last the
//   last beat produced by a given input byte.
//   Config channel: cfg_data sets the header skip length; always ready. The
//   user must keep it written only while the block is idle; not enforced.
// Timing
//   Beats pass the command queue, command register and output register.
//   Payload bytes pass at one per cycle when not stalled. A start code run
//   costs 5 output beats (6 for an H.265 start fragment); the 4-entry
//   command queue soaks these up and in_ready drops only when it is full.
// Reset
//   header_len returns to 12 and packet state clears; no sweep is needed.
// Stall
//   With out_ready low the output register holds its beat, the sequencer
//   waits and the queue fills; input is then back-pressured.
`default_nettype none
module rtp_fu_nal_reassembler
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [3:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       packet_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            nal_end,
    output logic            run_last
);

    rtpfu_pkg::cmd_t         push_cmd;
    rtpfu_pkg::cmd_t         q_data;
    rtpfu_pkg::fifo_status_t q_status;
    logic                    cmd_push;
    logic                    q_pop;
    logic                    accept;

    // config register is a plain flop: never back-pressures
    assign cfg_ready = 1'b1;
    assign in_ready  = !q_status.full;
    assign accept    = in_valid && in_ready;

    rtpfu_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid),
        .cfg_hdr_len (cfg_data),
        .accept      (accept),
        .in_byte     (in_byte),
        .packet_last (packet_last),
        .cmd_push    (cmd_push),
        .cmd         (push_cmd)
    );

    // a push only happens on accept, which implies the queue has room
    rtpfu_cmd_fifo u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (cmd_push),
        .wdata  (push_cmd),
        .pop    (q_pop),
        .rdata  (q_data),
        .status (q_status)
    );

    rtpfu_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_data),
        .q_empty   (q_status.empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .nal_end   (nal_end),
        .run_last  (run_last)
    );

endmodule
`default_nettype wire

### hw/rtl/rtpfu_checker.sv
// Port-level checks for the RTP FU reassembler, bound to the top level.
// Depends on rtp_fu_nal_reassembler_assert.svh.
`default_nettype none
`include "rtp_fu_nal_reassembler_assert.svh"
module rtpfu_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       nal_end,
    input wire logic       run_last
);

    // stalled output beat holds
    `RTPFU_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(nal_end) && $stable(run_last))

    // NAL end only ever lands on the final beat of a run
    `RTPFU_ASSERT_IMP(a_end_on_run_last, clk, rst_n, out_valid && nal_end, run_last)

    // a run, once started, is delivered without gaps
    `RTPFU_ASSERT_NXT(a_run_contiguous, clk, rst_n, out_valid && out_ready && !run_last, out_valid)

endmodule

bind rtp_fu_nal_reassembler rtpfu_checker u_rtpfu_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .nal_end   (nal_end),
    .run_last  (run_last)
);
`default_nettype wire
